// ===== rtl/core/fmi_pkg.sv =====
// Shared types and codes of the two-input Mamdani fuzzy engine.
package fmi_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_GRD_RD,
		S_GRD_CMP,
		S_GRD_DIV,
		S_RULE_RD,
		S_RULE_ACC,
		S_CEN_RD,
		S_CEN_MUL,
		S_CEN_SUM,
		S_CEN_WMUL,
		S_CEN_ACC,
		S_QUOT,
		S_DIV,
		S_FIX,
		S_DONE
	} state_t;

	localparam logic [1:0] REQ_EVAL = 2'd0;
	localparam logic [1:0] REQ_SET  = 2'd1;
	localparam logic [1:0] REQ_RULE = 2'd2;

	localparam logic [1:0] ST_EVALUATED = 2'd0;
	localparam logic [1:0] ST_WRITTEN   = 2'd1;
	localparam logic [1:0] ST_NO_FIRE   = 2'd2;

	localparam logic [1:0] TBL_FIRST  = 2'd0;
	localparam logic [1:0] TBL_SECOND = 2'd1;
	localparam logic [1:0] TBL_OUTPUT = 2'd2;

	localparam logic [1:0] CFG_FIRST_COUNT  = 2'd0;
	localparam logic [1:0] CFG_SECOND_COUNT = 2'd1;
	localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd2;

	localparam int          CNT_BITS  = 4;
	localparam int          GRADE_W   = 16;
	localparam int          FRAC_BITS = 15;
	localparam logic [15:0] GRADE_ONE = 16'h8000;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/core/fmi_div.sv =====
// Restoring divider, one quotient bit per cycle.
module fmi_div #(
	parameter int NW = 37,
	parameter int DW = 19
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NW-1:0]        dividend,
	input  logic [DW-1:0]        divisor,
	output fmi_pkg::div_stat_t   stat,
	output logic [NW-1:0]        quotient,
	output logic [DW-1:0]        remainder
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so DW bits hold it
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/fuzzy_mamdani_two_input_top.sv =====
// Top level of the two-input Mamdani fuzzy engine: tables, sequencer, datapath.
//
//  channel | dir | handshake               | payload
//  cfg     | in  | cfg_we                  | cfg_index, cfg_data (set counts)
//  s       | in  | s_tvalid / s_tready     | s_tuser req_type, s_tdata fields
//  m       | out | m_tvalid / m_tready     | m_tuser status, m_tdata crisp_output
//
// Write items are answered straight from the idle state. An evaluate item is
// worked on by the sequencer, and one shared bit-serial divider serves every
// sloped grade and the final mean (NW = VALUE_BITS + 18 + log2(MAX_SETS) bits
// of dividend). s_tready is low while an item is worked on and while a result
// waits in the output register.
// Reset clears the tables at once through per-entry valid bits.
module fuzzy_mamdani_two_input_top #(
	parameter int MAX_SETS   = 8,
	parameter int VALUE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [3:0]           cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// first_value, second_value, table_select, set_index, point_a, point_b,
	// point_c, point_d, rule_row, rule_column, rule_target, zero pad
	input  logic [((6*VALUE_BITS+14+7)/8)*8-1:0] s_tdata,
	// req_type
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// crisp_output, zero pad
	output logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata,
	// status
	output logic [1:0]           m_tuser
);

	localparam int V      = VALUE_BITS;
	localparam int OUT_TW = ((V + 7) / 8) * 8;
	localparam int IW     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int CNTW   = $clog2(MAX_SETS + 1);
	localparam int BPD    = 3 * MAX_SETS;
	localparam int BPAW   = $clog2(BPD);
	localparam int RD     = MAX_SETS * MAX_SETS;
	localparam int RAW    = $clog2(RD);
	localparam int CENW   = V + 2;
	localparam int PW     = V + 18;
	localparam int DENW   = 16 + $clog2(MAX_SETS);
	localparam int NUMW   = PW + $clog2(MAX_SETS);
	localparam int NW     = (NUMW > V + 15) ? NUMW : V + 15;
	localparam int DW     = (DENW > V) ? DENW : V;
	localparam int QW     = NW + 1;

	localparam logic signed [QW-1:0] Q_HI = $signed(QW'({1'b0, {(V-1){1'b1}}}));
	localparam logic signed [QW-1:0] Q_LO = -Q_HI - QW'(1);

	// ---- input unpacking ----
	logic signed [V-1:0] in_first, in_second, in_a, in_b, in_c, in_d;
	logic [1:0] in_tsel;
	logic [2:0] in_sidx, in_row, in_col, in_tgt;

	assign in_first  = s_tdata[V-1:0];
	assign in_second = s_tdata[2*V-1:V];
	assign in_tsel   = s_tdata[2*V+1:2*V];
	assign in_sidx   = s_tdata[2*V+4:2*V+2];
	assign in_a      = s_tdata[3*V+4:2*V+5];
	assign in_b      = s_tdata[4*V+4:3*V+5];
	assign in_c      = s_tdata[5*V+4:4*V+5];
	assign in_d      = s_tdata[6*V+4:5*V+5];
	assign in_row    = s_tdata[6*V+7:6*V+5];
	assign in_col    = s_tdata[6*V+10:6*V+8];
	assign in_tgt    = s_tdata[6*V+13:6*V+11];

	// ---- configuration ----
	logic [fmi_pkg::CNT_BITS-1:0] cnt1_q, cnt2_q, cnto_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q <= 4'd1;
			cnt2_q <= 4'd1;
			cnto_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				fmi_pkg::CFG_FIRST_COUNT:  cnt1_q <= cfg_data;
				fmi_pkg::CFG_SECOND_COUNT: cnt2_q <= cfg_data;
				fmi_pkg::CFG_OUTPUT_COUNT: cnto_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [CNTW-1:0] eff_count(input logic [fmi_pkg::CNT_BITS-1:0] raw);
		logic [CNTW-1:0] r;
		if (raw == '0)
			r = CNTW'(1);
		else if (32'(raw) > MAX_SETS)
			r = CNTW'(MAX_SETS);
		else
			r = CNTW'(raw);
		return r;
	endfunction

	// ---- state ----
	fmi_pkg::state_t state_q, state_d;

	logic accept;
	logic out_free;
	logic out_load_wr, out_load_ev;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == fmi_pkg::S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	logic            grp_q;
	logic [IW-1:0]   idx_q, jdx_q;
	logic [CNTW-1:0] n1_q, n2_q, no_q;
	logic signed [V-1:0] x1_q, x2_q;
	logic [15:0] g1_q [MAX_SETS];
	logic [15:0] g2_q [MAX_SETS];
	logic [15:0] u_q  [MAX_SETS];
	logic signed [NUMW-1:0] num_q;
	logic [DENW-1:0]        den_q;
	logic signed [PW-1:0]   prod_q, wprod_q;
	logic signed [CENW-1:0] centre_q;
	logic signed [V-1:0]    res_q;
	logic [1:0]             res_stat_q;

	// ---- breakpoint table, word = {d, c, b, a} ----
	logic [4*V-1:0] bp_mem [BPD];
	logic [BPD-1:0] bp_vld_q;
	logic [4*V-1:0] bp_rd_q;
	logic [BPAW-1:0] bp_waddr, bp_raddr;
	logic bp_we;

	assign bp_we    = accept && s_tuser == fmi_pkg::REQ_SET && in_tsel <= fmi_pkg::TBL_OUTPUT
		&& 32'(in_sidx) < MAX_SETS;
	assign bp_waddr = BPAW'(32'(in_tsel) * MAX_SETS + 32'(in_sidx));
	// output sets stay addressed for the whole centre sequence
	assign bp_raddr = (state_q inside {fmi_pkg::S_CEN_RD, fmi_pkg::S_CEN_MUL,
		fmi_pkg::S_CEN_SUM, fmi_pkg::S_CEN_WMUL, fmi_pkg::S_CEN_ACC})
		? BPAW'(2 * MAX_SETS + 32'(idx_q))
		: BPAW'(32'(grp_q) * MAX_SETS + 32'(idx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bp_vld_q <= '0;
		else if (bp_we)
			bp_vld_q[bp_waddr] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (bp_we)
			bp_mem[bp_waddr] <= {in_d, in_c, in_b, in_a};
		bp_rd_q <= bp_vld_q[bp_raddr] ? bp_mem[bp_raddr] : '0;
	end

	// ---- rule table ----
	logic [2:0]    rule_mem [RD];
	logic [RD-1:0] rule_vld_q;
	logic [2:0]    rule_rd_q;
	logic [RAW-1:0] rule_waddr, rule_raddr;
	logic rule_we;

	assign rule_we    = accept && s_tuser == fmi_pkg::REQ_RULE
		&& 32'(in_row) < MAX_SETS && 32'(in_col) < MAX_SETS;
	assign rule_waddr = RAW'(32'(in_row) * MAX_SETS + 32'(in_col));
	assign rule_raddr = RAW'(32'(idx_q) * MAX_SETS + 32'(jdx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rule_vld_q <= '0;
		else if (rule_we)
			rule_vld_q[rule_waddr] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (rule_we)
			rule_mem[rule_waddr] <= in_tgt;
		rule_rd_q <= rule_vld_q[rule_raddr] ? rule_mem[rule_raddr] : 3'd0;
	end

	// ---- shared divider ----
	logic                div_start;
	logic                div_final;
	fmi_pkg::div_stat_t  div_stat;
	logic [NW-1:0]       div_n, div_q;
	logic [DW-1:0]       div_d, div_r;

	fmi_div #(.NW(NW), .DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.stat     (div_stat),
		.quotient (div_q),
		.remainder(div_r)
	);

	// ---- grading ----
	logic signed [V-1:0] bx, ba, bb, bc, bd;
	logic signed [V:0]   rise_n, rise_d, fall_n, fall_d;
	logic [1:0] grd_kind;   // 0 constant, 1 rising divide, 2 falling divide
	logic [15:0] grd_const;
	logic [IW-1:0] grp_n;
	logic grd_last;

	assign bx = grp_q ? x2_q : x1_q;
	assign ba = bp_rd_q[V-1:0];
	assign bb = bp_rd_q[2*V-1:V];
	assign bc = bp_rd_q[3*V-1:2*V];
	assign bd = bp_rd_q[4*V-1:3*V];
	assign rise_n = (V+1)'(bx) - (V+1)'(ba);
	assign rise_d = (V+1)'(bb) - (V+1)'(ba);
	assign fall_n = (V+1)'(bd) - (V+1)'(bx);
	assign fall_d = (V+1)'(bd) - (V+1)'(bc);
	assign grd_last = (CNTW'(idx_q) + 1'b1) == (grp_q ? n2_q : n1_q);
	assign grp_n = idx_q;

	always_comb begin
		grd_kind  = 2'd0;
		grd_const = '0;
		if (bx < ba) begin
			grd_const = '0;
		end else if (bx <= bb) begin
			if (bb == ba) grd_const = fmi_pkg::GRADE_ONE;
			else grd_kind = 2'd1;
		end else if (bx < bc) begin
			grd_const = fmi_pkg::GRADE_ONE;
		end else if (bx <= bd) begin
			if (bd == bc) grd_const = fmi_pkg::GRADE_ONE;
			else grd_kind = 2'd2;
		end
	end

	// ---- final quotient ----
	logic [NUMW-1:0]     num_mag;
	logic signed [QW-1:0] q_s;
	logic signed [V-1:0]  q_sat;

	assign num_mag = num_q[NUMW-1] ? NUMW'(-num_q) : NUMW'(num_q);

	always_comb begin
		if (div_final) begin
			div_n = NW'(num_mag);
			div_d = DW'(den_q);
		end else if (grd_kind == 2'd2) begin
			div_n = NW'({fall_n[V-1:0], {fmi_pkg::FRAC_BITS{1'b0}}});
			div_d = DW'(fall_d[V-1:0]);
		end else begin
			div_n = NW'({rise_n[V-1:0], {fmi_pkg::FRAC_BITS{1'b0}}});
			div_d = DW'(rise_d[V-1:0]);
		end
	end

	always_comb begin
		// floor for a negative mean: round the magnitude quotient away from zero
		if (num_q[NUMW-1])
			q_s = -$signed({1'b0, div_q}) - QW'(div_r != '0);
		else
			q_s = $signed({1'b0, div_q});
		if (q_s > Q_HI)
			q_sat = {1'b0, {(V-1){1'b1}}};
		else if (q_s < Q_LO)
			q_sat = {1'b1, {(V-1){1'b0}}};
		else
			q_sat = q_s[V-1:0];
	end

	// ---- rule and centre terms ----
	logic [15:0] w_min, u_cur, u_tgt;
	logic [IW-1:0] t_ix;
	logic t_ok;
	logic rule_jlast, rule_ilast, cen_last;
	logic signed [V+1:0] cen_diff;
	logic signed [PW-1:0] cen_s;

	assign w_min = (g1_q[idx_q] > g2_q[jdx_q]) ? g2_q[jdx_q] : g1_q[idx_q];
	assign t_ix  = IW'(rule_rd_q);
	assign t_ok  = 32'(rule_rd_q) < 32'(no_q);
	assign u_tgt = u_q[t_ix];
	assign u_cur = u_q[idx_q];
	assign rule_jlast = (CNTW'(jdx_q) + 1'b1) == n2_q;
	assign rule_ilast = (CNTW'(idx_q) + 1'b1) == n1_q;
	assign cen_last   = (CNTW'(idx_q) + 1'b1) == no_q;
	assign cen_diff   = (V+2)'(rise_d) - (V+2)'(fall_d);
	assign cen_s      = ((PW'(ba) + PW'(bd)) <<< fmi_pkg::FRAC_BITS) + prod_q;

	// ---- next state ----
	always_comb begin
		state_d     = state_q;
		div_start   = 1'b0;
		div_final   = 1'b0;
		out_load_wr = 1'b0;
		out_load_ev = 1'b0;
		case (state_q)
			fmi_pkg::S_IDLE: begin
				if (accept) begin
					if (s_tuser == fmi_pkg::REQ_EVAL) state_d = fmi_pkg::S_GRD_RD;
					else out_load_wr = 1'b1;
				end
			end
			fmi_pkg::S_GRD_RD: state_d = fmi_pkg::S_GRD_CMP;
			fmi_pkg::S_GRD_CMP: begin
				if (grd_kind != 2'd0) begin
					div_start = 1'b1;
					state_d   = fmi_pkg::S_GRD_DIV;
				end else if (grd_last && grp_q) begin
					state_d = fmi_pkg::S_RULE_RD;
				end else begin
					state_d = fmi_pkg::S_GRD_RD;
				end
			end
			fmi_pkg::S_GRD_DIV: begin
				if (div_stat.done)
					state_d = (grd_last && grp_q) ? fmi_pkg::S_RULE_RD : fmi_pkg::S_GRD_RD;
			end
			fmi_pkg::S_RULE_RD: state_d = fmi_pkg::S_RULE_ACC;
			fmi_pkg::S_RULE_ACC:
				state_d = (rule_jlast && rule_ilast) ? fmi_pkg::S_CEN_RD : fmi_pkg::S_RULE_RD;
			fmi_pkg::S_CEN_RD: begin
				if (u_cur != '0) state_d = fmi_pkg::S_CEN_MUL;
				else if (cen_last) state_d = fmi_pkg::S_QUOT;
			end
			fmi_pkg::S_CEN_MUL:  state_d = fmi_pkg::S_CEN_SUM;
			fmi_pkg::S_CEN_SUM:  state_d = fmi_pkg::S_CEN_WMUL;
			fmi_pkg::S_CEN_WMUL: state_d = fmi_pkg::S_CEN_ACC;
			fmi_pkg::S_CEN_ACC:  state_d = cen_last ? fmi_pkg::S_QUOT : fmi_pkg::S_CEN_RD;
			fmi_pkg::S_QUOT: begin
				if (den_q == '0) begin
					state_d = fmi_pkg::S_DONE;
				end else begin
					div_final = 1'b1;
					div_start = 1'b1;
					state_d   = fmi_pkg::S_DIV;
				end
			end
			fmi_pkg::S_DIV: begin
				div_final = 1'b1;
				if (div_stat.done) state_d = fmi_pkg::S_FIX;
			end
			fmi_pkg::S_FIX: begin
				div_final = 1'b1;
				state_d   = fmi_pkg::S_DONE;
			end
			fmi_pkg::S_DONE: begin
				if (out_free) begin
					out_load_ev = 1'b1;
					state_d     = fmi_pkg::S_IDLE;
				end
			end
			default: state_d = fmi_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= fmi_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// ---- sequencer counters ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= 1'b0;
			idx_q <= '0;
			jdx_q <= '0;
		end else begin
			case (state_q)
				fmi_pkg::S_IDLE: begin
					grp_q <= 1'b0;
					idx_q <= '0;
					jdx_q <= '0;
				end
				fmi_pkg::S_GRD_CMP, fmi_pkg::S_GRD_DIV: begin
					if ((state_q == fmi_pkg::S_GRD_CMP && grd_kind == 2'd0) ||
					    (state_q == fmi_pkg::S_GRD_DIV && div_stat.done)) begin
						if (grd_last) begin
							grp_q <= 1'b1;
							idx_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				fmi_pkg::S_RULE_ACC: begin
					if (rule_jlast) begin
						jdx_q <= '0;
						idx_q <= rule_ilast ? '0 : idx_q + 1'b1;
					end else begin
						jdx_q <= jdx_q + 1'b1;
					end
				end
				fmi_pkg::S_CEN_RD: begin
					if (u_cur == '0 && !cen_last) idx_q <= idx_q + 1'b1;
				end
				fmi_pkg::S_CEN_ACC: begin
					if (!cen_last) idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// ---- datapath ----
	always_ff @(posedge clk) begin
		case (state_q)
			fmi_pkg::S_IDLE: begin
				x1_q  <= in_first;
				x2_q  <= in_second;
				n1_q  <= eff_count(cnt1_q);
				n2_q  <= eff_count(cnt2_q);
				no_q  <= eff_count(cnto_q);
				num_q <= '0;
				den_q <= '0;
				for (int k = 0; k < MAX_SETS; k++) u_q[k] <= '0;
			end
			fmi_pkg::S_GRD_CMP: begin
				if (grd_kind == 2'd0) begin
					if (grp_q) g2_q[grp_n] <= grd_const;
					else g1_q[grp_n] <= grd_const;
				end
			end
			fmi_pkg::S_GRD_DIV: begin
				if (div_stat.done) begin
					if (grp_q) g2_q[grp_n] <= div_q[15:0];
					else g1_q[grp_n] <= div_q[15:0];
				end
			end
			fmi_pkg::S_RULE_ACC: begin
				if (t_ok && u_tgt < w_min) u_q[t_ix] <= w_min;
			end
			fmi_pkg::S_CEN_MUL: prod_q <= PW'($signed({1'b0, u_cur})) * PW'(cen_diff);
			fmi_pkg::S_CEN_SUM: centre_q <= CENW'(cen_s >>> 16);
			fmi_pkg::S_CEN_WMUL: wprod_q <= PW'($signed({1'b0, u_cur})) * PW'(centre_q);
			fmi_pkg::S_CEN_ACC: begin
				num_q <= num_q + NUMW'(wprod_q);
				den_q <= den_q + DENW'(u_cur);
			end
			fmi_pkg::S_QUOT: begin
				res_q      <= '0;
				res_stat_q <= fmi_pkg::ST_NO_FIRE;
			end
			fmi_pkg::S_FIX: begin
				res_q      <= q_sat;
				res_stat_q <= fmi_pkg::ST_EVALUATED;
			end
			default: ;
		endcase
	end

	// ---- output register ----
	logic [1:0]   m_stat_q;
	logic [V-1:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (out_load_wr || out_load_ev)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load_wr) begin
			m_stat_q <= fmi_pkg::ST_WRITTEN;
			m_data_q <= '0;
		end else if (out_load_ev) begin
			m_stat_q <= res_stat_q;
			m_data_q <= res_q;
		end
	end

	assign m_tuser = m_stat_q;
	assign m_tdata = OUT_TW'(m_data_q);

endmodule

// ===== verif/tb_fuzzy_mamdani_two_input_top.sv =====
// Testbench for the two-input Mamdani fuzzy engine: directed table, then random phases.
module tb_fuzzy_mamdani_two_input_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSETS = 8;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD = 300;
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam logic [1:0] TBL_NONE = 2'd3;

	typedef struct {
		logic [1:0]         req;
		logic signed [15:0] x1, x2;
		logic [1:0]         tsel;
		logic [2:0]         idx;
		logic signed [15:0] pa, pb, pc, pd;
		logic [2:0]         row, col, tgt;
	} fz_item_t;

	typedef struct {
		fz_item_t           it;
		bit                 known;
		logic [1:0]         st;
		logic signed [15:0] cr;
	} fz_row_t;

	typedef struct {
		logic [1:0]         st;
		logic signed [15:0] cr;
	} fz_res_t;

	logic         clk, arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [3:0]   cfg_data;
	logic         s_tvalid, s_tready;
	logic [111:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid, m_tready;
	logic [15:0]  m_tdata;
	logic [1:0]   m_tuser;

	fuzzy_mamdani_two_input_top dut (.*);

	// predictor state
	longint     bp [3][NSETS][4];
	logic [2:0] rule_tgt [NSETS][NSETS];
	logic [3:0] cnt [3];

	fz_res_t  expq[$];
	fz_row_t  dir_rows[$];
	int       sent = 0, n_eval = 0, n_nofire = 0, n_write = 0, n_mism = 0, n_checked = 0;
	bit       pressed = 0, quiet = 0, failed = 0;
	int       stall_cnt = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic int eff(logic [3:0] c);
		if (c == 0) return 1;
		if (c > NSETS) return NSETS;
		return c;
	endfunction

	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q--;
		return q;
	endfunction

	function automatic longint grade_of(int g, int s, longint x);
		longint a, b, c, d;
		a = bp[g][s][0]; b = bp[g][s][1]; c = bp[g][s][2]; d = bp[g][s][3];
		if (x < a) return 0;
		if (x <= b) return (b == a) ? 32768 : ((x - a) * 32768) / (b - a);
		if (x < c) return 32768;
		if (x <= d) return (d == c) ? 32768 : ((d - x) * 32768) / (d - c);
		return 0;
	endfunction

	function automatic fz_res_t infer(fz_item_t it);
		fz_res_t r;
		longint g1[NSETS], g2[NSETS], u[NSETS];
		longint num, den, w, a, b, c, d, cen;
		int n1, n2, no;
		r.st = fmi_pkg::ST_WRITTEN;
		r.cr = 0;
		num = 0;
		den = 0;
		case (it.req)
			fmi_pkg::REQ_SET: if (it.tsel != TBL_NONE) begin
				bp[it.tsel][it.idx][0] = it.pa;
				bp[it.tsel][it.idx][1] = it.pb;
				bp[it.tsel][it.idx][2] = it.pc;
				bp[it.tsel][it.idx][3] = it.pd;
			end
			fmi_pkg::REQ_RULE: rule_tgt[it.row][it.col] = it.tgt;
			fmi_pkg::REQ_EVAL: begin
				n1 = eff(cnt[fmi_pkg::CFG_FIRST_COUNT]);
				n2 = eff(cnt[fmi_pkg::CFG_SECOND_COUNT]);
				no = eff(cnt[fmi_pkg::CFG_OUTPUT_COUNT]);
				for (int i = 0; i < NSETS; i++) begin
					g1[i] = grade_of(fmi_pkg::TBL_FIRST, i, it.x1);
					g2[i] = grade_of(fmi_pkg::TBL_SECOND, i, it.x2);
					u[i] = 0;
				end
				for (int i = 0; i < n1; i++)
					for (int j = 0; j < n2; j++) begin
						w = (g1[i] > g2[j]) ? g2[j] : g1[i];
						if (rule_tgt[i][j] < no && u[rule_tgt[i][j]] < w)
							u[rule_tgt[i][j]] = w;
					end
				for (int i = 0; i < no; i++)
					if (u[i] != 0) begin
						a = bp[fmi_pkg::TBL_OUTPUT][i][0]; b = bp[fmi_pkg::TBL_OUTPUT][i][1];
						c = bp[fmi_pkg::TBL_OUTPUT][i][2]; d = bp[fmi_pkg::TBL_OUTPUT][i][3];
						cen = fdiv(32768 * (a + d) + u[i] * ((b - a) - (d - c)), 65536);
						num += u[i] * cen;
						den += u[i];
					end
				if (den == 0) begin
					r.st = fmi_pkg::ST_NO_FIRE;
				end else begin
					w = fdiv(num, den);
					if (w > 32767) w = 32767;
					if (w < -32768) w = -32768;
					r.st = fmi_pkg::ST_EVALUATED;
					r.cr = w;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic fz_item_t noise_item();
		fz_item_t it;
		it.req = $urandom; it.x1 = $urandom; it.x2 = $urandom;
		it.tsel = $urandom; it.idx = $urandom;
		it.pa = $urandom; it.pb = $urandom; it.pc = $urandom; it.pd = $urandom;
		it.row = $urandom; it.col = $urandom; it.tgt = $urandom;
		return it;
	endfunction

	// trapezoid: mostly ordered around a random centre, some degenerate shapes
	function automatic fz_item_t trap_item(logic [1:0] tsel, logic [2:0] idx);
		fz_item_t it;
		int c0, w1, w2, w3, w4;
		it = noise_item();
		it.req = fmi_pkg::REQ_SET;
		it.tsel = tsel;
		it.idx = idx;
		c0 = int'($urandom_range(0, 4000)) - 2000;
		w2 = $urandom_range(0, 300);
		w1 = w2 + $urandom_range(0, 900);
		w3 = $urandom_range(0, 300);
		w4 = w3 + $urandom_range(0, 900);
		case ($urandom_range(0, 7))
			0: begin w2 = 0; w3 = 0; end
			1: w1 = w2;
			2: w4 = w3;
			default: ;
		endcase
		if ($urandom_range(0, 11) != 0) begin
			it.pa = c0 - w1; it.pb = c0 - w2; it.pc = c0 + w3; it.pd = c0 + w4;
		end
		return it;
	endfunction

	// known rows carry their own expected result; the predictor still tracks the tables
	task automatic send(fz_item_t it, bit known = 1'b0, logic [1:0] kst = '0,
		logic signed [15:0] kcr = '0);
		fz_res_t r;
		s_tvalid <= 1'b1;
		s_tuser <= it.req;
		s_tdata <= {2'b00, it.tgt, it.col, it.row, it.pd, it.pc, it.pb, it.pa,
			it.idx, it.tsel, it.x2, it.x1};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = infer(it);
		if (known) begin
			r.st = kst;
			r.cr = kcr;
		end
		expq.push_back(r);
		sent++;
		if (it.req == fmi_pkg::REQ_EVAL) n_eval++; else n_write++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// only called right after an item went in or while the input is idle
	task automatic write_counts(logic [3:0] c0, logic [3:0] c1, logic [3:0] c2);
		logic [3:0] v[3];
		v[0] = c0; v[1] = c1; v[2] = c2;
		s_tvalid <= 1'b0;
		while (expq.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		for (int k = fmi_pkg::CFG_FIRST_COUNT; k <= fmi_pkg::CFG_OUTPUT_COUNT; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= k;
			cfg_data <= v[k];
			cnt[k] = v[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expq.size() == 0) begin
				failed = 1;
				n_mism++;
				if (n_mism <= 10)
					$display("unexpected result: status %0d crisp %0d", m_tuser,
						$signed(m_tdata));
			end else begin
				fz_res_t e;
				e = expq.pop_front();
				n_checked++;
				if (e.st == fmi_pkg::ST_NO_FIRE) n_nofire++;
				if (m_tuser !== e.st || m_tdata !== e.cr) begin
					failed = 1;
					n_mism++;
					if (n_mism <= 10)
						$display("mismatch: status exp %0d got %0d, crisp exp %0d got %0d",
							e.st, m_tuser, e.cr, $signed(m_tdata));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("FAIL fuzzy_mamdani_two_input_top");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off so the block backs up
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!pressed && sent >= 100) begin
				pressed = 1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic add_row(fz_item_t it, bit known, logic [1:0] st, logic signed [15:0] cr);
		fz_row_t r;
		r.it = it; r.known = known; r.st = st; r.cr = cr;
		dir_rows.push_back(r);
	endtask

	function automatic fz_item_t ev(logic signed [15:0] x1, logic signed [15:0] x2);
		fz_item_t it;
		it = noise_item();
		it.req = fmi_pkg::REQ_EVAL; it.x1 = x1; it.x2 = x2;
		return it;
	endfunction

	function automatic fz_item_t st_it(logic [1:0] tsel, logic [2:0] idx,
		logic signed [15:0] a, logic signed [15:0] b, logic signed [15:0] c,
		logic signed [15:0] d);
		fz_item_t it;
		it = noise_item();
		it.req = fmi_pkg::REQ_SET; it.tsel = tsel; it.idx = idx;
		it.pa = a; it.pb = b; it.pc = c; it.pd = d;
		return it;
	endfunction

	function automatic fz_item_t ru_it(logic [2:0] r, logic [2:0] c, logic [2:0] t);
		fz_item_t it;
		it = noise_item();
		it.req = fmi_pkg::REQ_RULE; it.row = r; it.col = c; it.tgt = t;
		return it;
	endfunction

	initial begin
		fz_item_t it;
		logic [3:0] c[3];
		int nev;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0;
		foreach (bp[g, s, k]) bp[g][s][k] = 0;
		foreach (rule_tgt[i, j]) rule_tgt[i][j] = 0;
		foreach (cnt[k]) cnt[k] = 1;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state first, then extremes and corner cases
		add_row(ev(0, 0), 1, fmi_pkg::ST_EVALUATED, 0);
		add_row(ev(1, 0), 1, fmi_pkg::ST_NO_FIRE, 0);
		add_row(ev(-32768, 32767), 1, fmi_pkg::ST_NO_FIRE, 0);
		it = noise_item(); it.req = REQ_NONE;
		add_row(it, 1, fmi_pkg::ST_WRITTEN, 0);
		add_row(st_it(TBL_NONE, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff),
			1, fmi_pkg::ST_WRITTEN, 0);
		add_row(st_it(fmi_pkg::TBL_FIRST, 0, -32768, 0, 0, 32767), 1, fmi_pkg::ST_WRITTEN, 0);
		add_row(st_it(fmi_pkg::TBL_SECOND, 0, -100, -100, 100, 100), 1, fmi_pkg::ST_WRITTEN, 0);
		add_row(st_it(fmi_pkg::TBL_OUTPUT, 0, -512, 0, 0, 1024), 1, fmi_pkg::ST_WRITTEN, 0);
		add_row(ru_it(0, 0, 0), 1, fmi_pkg::ST_WRITTEN, 0);
		add_row(ev(-16384, -100), 0, 0, 0);
		add_row(ev(32767, 100), 0, 0, 0);
		add_row(ev(-32768, 0), 0, 0, 0);
		add_row(ev(300, 101), 0, 0, 0);
		add_row(st_it(fmi_pkg::TBL_OUTPUT, 0, 32767, 32767, 32767, 32767),
			1, fmi_pkg::ST_WRITTEN, 0);
		add_row(ev(0, 50), 0, 0, 0);
		add_row(st_it(fmi_pkg::TBL_OUTPUT, 0, -32768, -32768, -32768, -32768),
			1, fmi_pkg::ST_WRITTEN, 0);
		add_row(ev(0, 50), 0, 0, 0);
		// badly ordered breakpoints
		add_row(st_it(fmi_pkg::TBL_FIRST, 0, 100, -100, 50, -50), 1, fmi_pkg::ST_WRITTEN, 0);
		add_row(ev(75, 0), 0, 0, 0);
		add_row(ev(-75, 0), 0, 0, 0);
		add_row(ru_it(7, 7, 7), 1, fmi_pkg::ST_WRITTEN, 0);
		add_row(ru_it(0, 0, 7), 1, fmi_pkg::ST_WRITTEN, 0);
		add_row(ev(75, 0), 0, 0, 0);
		add_row(ru_it(0, 0, 0), 1, fmi_pkg::ST_WRITTEN, 0);

		foreach (dir_rows[k])
			send(dir_rows[k].it, dir_rows[k].known, dir_rows[k].st, dir_rows[k].cr);

		// random phases: counts, tables, rules, then evaluations with some noise
		for (int ph = 0; sent < 360; ph++) begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(0, 9))
					0: c[k] = 0;
					1: c[k] = NSETS;
					2: c[k] = 4'hf;
					default: c[k] = $urandom_range(1, 4);
				endcase
			end
			if (ph == 1) begin c[0] = NSETS; c[1] = NSETS; c[2] = NSETS; end
			if (ph == 2) begin c[0] = 1; c[1] = 1; c[2] = 1; end
			write_counts(c[0], c[1], c[2]);
			for (int g = fmi_pkg::TBL_FIRST; g <= fmi_pkg::TBL_OUTPUT; g++)
				for (int s = 0; s < NSETS; s++)
					if (s < eff(c[g]) || $urandom_range(0, 7) == 0)
						send(trap_item(g, s));
			for (int r = 0; r < eff(c[0]); r++)
				for (int q = 0; q < eff(c[1]); q++)
					if ($urandom_range(0, 3) != 0)
						send(ru_it(r, q, $urandom_range(0, eff(c[2]))));
			nev = $urandom_range(10, 25);
			for (int k = 0; k < nev; k++) begin
				quiet = (sent >= 330);
				if ($urandom_range(0, 9) == 0) begin
					send(noise_item());
				end else begin
					it = ev(int'($urandom_range(0, 5000)) - 2500,
						int'($urandom_range(0, 5000)) - 2500);
					if ($urandom_range(0, 9) == 0) it.x1 = $urandom;
					if ($urandom_range(0, 9) == 0) it.x2 = $urandom;
					send(it);
				end
			end
		end

		s_tvalid <= 1'b0;
		quiet = 1;
		while (expq.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d items: %0d evaluations (%0d with no rule fired), %0d writes",
			sent, n_eval, n_nofire, n_write);
		$display("%0d results checked, %0d mismatches", n_checked, n_mism);
		if (!failed) begin
			$display("PASS fuzzy_mamdani_two_input_top");
		end else begin
			$display("FAIL fuzzy_mamdani_two_input_top");
		end
		$finish;
	end
endmodule

// ===== fuzzy_mamdani_two_input_top.f =====
rtl/core/fmi_pkg.sv
rtl/core/fmi_div.sv
rtl/core/fuzzy_mamdani_two_input_top.sv
verif/tb_fuzzy_mamdani_two_input_top.sv
